@@ rtl/core/ring_buffer_stack_rotate_swap_assert.svh @@
// Assertion macros for the ring buffer stack checker.
// Depends on nothing; included by the checker file.
`ifndef RING_BUFFER_STACK_ROTATE_SWAP_ASSERT_SVH
`define RING_BUFFER_STACK_ROTATE_SWAP_ASSERT_SVH

// Plain property, checked at every rising edge outside reset
`define RBSRS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication, checked at every rising edge outside reset
`define RBSRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/rbsrs_pkg.sv @@
// Shared types and codes for the ring buffer stack.
// No dependencies; imported by the top level and the checker.
package rbsrs_pkg;

  // Operation codes
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_SWAP = 3'd2;
  localparam logic [2:0] OP_ROT  = 3'd3;
  localparam logic [2:0] OP_RROT = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [31:0]  push_value;
  } rbsrs_req_t;

  typedef struct packed {
    logic signed [31:0]  out_value;
    logic [1:0]          status;
    logic [9:0]          count;
  } rbsrs_rsp_t;

endpackage

@@ rtl/core/rbsrs_store.sv @@
// Entry store: one write port, one registered read port, write forwarding.
// Depends on nothing but its parameters.
module rbsrs_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic signed [31:0]    wdata,
  input  logic [AW-1:0]         raddr,
  output logic signed [31:0]    rdata
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_q;
  logic signed [31:0] fwd_data;
  logic               fwd_hit;

  // Write and read the array; the read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Remember a write that lands on the address being read
  always_ff @(posedge clk) begin
    fwd_hit  <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

@@ rtl/core/ring_buffer_stack_rotate_swap.sv @@
// Top level of the ring buffer stack: index control, top-entry register, results.
// Depends on rbsrs_pkg and rbsrs_store.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------
//   command   | start, busy (in on s & !b)| request: op, push_value
//   result    | done (one-cycle strobe)   | result: out_value, status, count
//
// One item is taken every cycle; busy is high only during reset.
// A result passes the stage register and the result register: indices and the store
// read move at acceptance, the store write and top-entry update from the stage register.
// The single write port of the store carries at most one write per item.
// Reset clears indices and count; the store needs no clearing pass.
// The receiver cannot stall, so only reset holds off the command side.
module ring_buffer_stack_rotate_swap #(
  parameter int CAPACITY = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rbsrs_pkg::rbsrs_req_t request,
  output logic                 done,
  output rbsrs_pkg::rbsrs_rsp_t result
);

  import rbsrs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  typedef struct packed {
    logic               valid;
    logic               pop;
    logic               load_push;
    logic               load_rd;
    logic               we;
    logic [IW-1:0]      wa;
    logic signed [31:0] push_value;
    logic [1:0]         status;
    logic [9:0]         count;
  } stage_t;

  logic [IW-1:0]      top_index;
  logic [IW-1:0]      top_index_next;
  logic [IW-1:0]      bottom_index;
  logic [IW-1:0]      bottom_index_next;
  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      entry_count_next;
  logic signed [31:0] top_value;
  stage_t             stage;
  stage_t             stage_next;
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  logic               accept;
  logic               is_empty;
  logic               is_full;
  logic               has_two;
  logic [IW-1:0]      top_up;
  logic [IW-1:0]      top_dn;
  logic [IW-1:0]      bot_up;
  logic [IW-1:0]      bot_dn;

  assign busy   = rst;
  assign accept = start && !busy;

  // Neighbor slots, wrapping at the capacity
  assign top_up = (top_index == LAST_SLOT) ? '0 : top_index + IW'(1);
  assign top_dn = (top_index == '0) ? LAST_SLOT : top_index - IW'(1);
  assign bot_up = (bottom_index == LAST_SLOT) ? '0 : bottom_index + IW'(1);
  assign bot_dn = (bottom_index == '0) ? LAST_SLOT : bottom_index - IW'(1);

  assign is_empty = (entry_count == '0);
  assign is_full  = (entry_count == FULL_CNT);
  assign has_two  = (entry_count > CW'(1));

  // Decode the incoming item: new indices, store read, deferred write
  always_comb begin
    top_index_next       = top_index;
    bottom_index_next    = bottom_index;
    entry_count_next     = entry_count;
    rd_addr              = top_up;
    stage_next           = '0;
    stage_next.valid     = accept;
    stage_next.wa        = top_index;
    stage_next.push_value = request.push_value;
    stage_next.status    = ST_OK;
    case (request.op)
      OP_PUSH: begin
        if (is_full) begin
          stage_next.status = ST_FULL;
        end else begin
          if (is_empty) begin
            top_index_next    = LAST_SLOT;
            bottom_index_next = LAST_SLOT;
          end else begin
            top_index_next = top_dn;
          end
          // Spill the old top into its slot
          stage_next.we        = !is_empty;
          stage_next.wa        = top_index;
          stage_next.load_push = 1'b1;
          entry_count_next     = entry_count + CW'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          stage_next.status = ST_EMPTY;
        end else begin
          if (entry_count == CW'(1)) begin
            top_index_next    = '0;
            bottom_index_next = '0;
          end else begin
            top_index_next = top_up;
          end
          rd_addr            = top_up;
          stage_next.pop     = 1'b1;
          stage_next.load_rd = 1'b1;
          entry_count_next   = entry_count - CW'(1);
        end
      end
      OP_SWAP: begin
        if (has_two) begin
          rd_addr            = top_up;
          stage_next.we      = 1'b1;
          stage_next.wa      = top_up;
          stage_next.load_rd = 1'b1;
        end
      end
      OP_ROT: begin
        if (has_two) begin
          rd_addr            = top_up;
          stage_next.we      = 1'b1;
          stage_next.wa      = bot_up;
          stage_next.load_rd = 1'b1;
          top_index_next     = top_up;
          bottom_index_next  = bot_up;
        end
      end
      OP_RROT: begin
        if (has_two) begin
          rd_addr            = bottom_index;
          stage_next.we      = 1'b1;
          stage_next.wa      = top_index;
          stage_next.load_rd = 1'b1;
          top_index_next     = top_dn;
          bottom_index_next  = bot_dn;
        end
      end
      default: begin
      end
    endcase
    stage_next.count = 10'(entry_count_next);
  end

  // Advance indices and count on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      top_index    <= '0;
      bottom_index <= '0;
      entry_count  <= '0;
    end else if (accept) begin
      top_index    <= top_index_next;
      bottom_index <= bottom_index_next;
      entry_count  <= entry_count_next;
    end
  end

  // Hold the decoded item for the write and top-update cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.pop        <= stage_next.pop;
    stage.load_push  <= stage_next.load_push;
    stage.load_rd    <= stage_next.load_rd;
    stage.we         <= stage_next.we;
    stage.wa         <= stage_next.wa;
    stage.push_value <= stage_next.push_value;
    stage.status     <= stage_next.status;
    stage.count      <= stage_next.count;
  end

  rbsrs_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (stage.valid && stage.we),
    .waddr (stage.wa),
    .wdata (top_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Keep the top entry in a register; the store is stale at the top slot
  always_ff @(posedge clk) begin
    if (stage.valid && stage.load_push) begin
      top_value <= stage.push_value;
    end else if (stage.valid && stage.load_rd) begin
      top_value <= rd_data;
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
    result.out_value <= stage.pop ? top_value : '0;
    result.status    <= stage.status;
    result.count     <= stage.count;
  end

endmodule

@@ rtl/core/rbsrs_checker.sv @@
// Port-level checks for the ring buffer stack, bound to the top level.
// Depends on rbsrs_pkg and ring_buffer_stack_rotate_swap_assert.svh.
`include "ring_buffer_stack_rotate_swap_assert.svh"

module rbsrs_checker #(
  parameter int CAPACITY = 512
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input rbsrs_pkg::rbsrs_req_t request,
  input logic                  done,
  input rbsrs_pkg::rbsrs_rsp_t result
);

  import rbsrs_pkg::*;

  // Every item gets its result through the stage and result registers, and only then
  `RBSRS_ASSERT_IMPL(a_item_gets_result, clk, rst, start && !busy, ##2 done, "item lost")
  `RBSRS_ASSERT_IMPL(a_result_has_item, clk, rst, done, $past(start && !busy, 2), "result invented")

  // A failed pop leaves an empty stack; a failed push leaves a full one
  `RBSRS_ASSERT_IMPL(a_empty_count, clk, rst, done && (result.status == ST_EMPTY), (result.count == '0) && (result.out_value == '0), "pop on empty with entries")
  `RBSRS_ASSERT_IMPL(a_full_count, clk, rst, done && (result.status == ST_FULL), result.count == 10'(CAPACITY), "push on full below capacity")

  // Only a pop returns a value
  `RBSRS_ASSERT_IMPL(a_value_from_pop, clk, rst, done && (result.out_value != '0), $past(request.op, 2) == OP_POP, "value without pop")

endmodule

bind ring_buffer_stack_rotate_swap rbsrs_checker #(
  .CAPACITY (CAPACITY)
) u_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
